// File: rtl/pearson_correlation_accumulator_core_defines.svh
// Assertion macros for the Pearson correlation accumulator core.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef PEARSON_CORRELATION_ACCUMULATOR_CORE_DEFINES_SVH
`define PEARSON_CORRELATION_ACCUMULATOR_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pca assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PCA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pca assertion failed");

`endif

// File: rtl/pca_pkg.sv
// Shared widths, codes and controller/datapath interface types for the
// Pearson correlation accumulator core. No dependencies.
`timescale 1ns / 1ps

package pca_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_PAIRS   = 64;
    localparam int CNT_W       = 7;
    localparam int SUM_W       = 22;
    localparam int SQ_W        = 38;
    localparam int DIFF_W      = 45;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int REM_W       = PROD_W + 1;
    localparam int QUO_W       = 31;
    localparam int ROOT_W      = 16;
    localparam int CORR_W      = 16;
    localparam int DET_W       = 16;
    localparam int REL_W       = 2;
    localparam int DET_SHIFT   = QUO_W - 1 - DET_W;
    localparam int MUL_STEPS   = DIFF_W;
    localparam int DIV_STEPS   = QUO_W;
    localparam int SQRT_STEPS  = ROOT_W;
    localparam int ITER_W      = 6;

    typedef enum logic [REL_W-1:0] {
        REL_POS  = 2'd0,
        REL_NEG  = 2'd1,
        REL_NONE = 2'd2
    } rel_t;

    typedef enum logic [6:0] {
        S_ACC   = 7'b0000001,
        S_PREP  = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_DLOAD = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_SQRT  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic              acc_en;
        logic              prep_en;
        logic              mul_en;
        logic              dload_en;
        logic              div_en;
        logic              sqrt_en;
        logic              out_load;
        logic [ITER_W-1:0] iter;
    } cmd_t;

    typedef struct packed {
        logic skip;
    } sts_t;

endpackage

// File: rtl/pca_ctrl.sv
// Controller state machine for the Pearson correlation accumulator core.
// Depends on pca_pkg; drives the datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps

module pca_ctrl
    import pca_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic last_pair,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t            state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              out_valid_reg, out_valid_next;
    logic              fire;

    assign in_ready  = (state_reg == S_ACC);
    assign out_valid = out_valid_reg;
    assign fire      = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.iter       = iter_reg;
        case (state_reg)
            S_ACC:
            begin
                cmd.acc_en = fire;
                if (fire && last_pair)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep_en = 1'b1;
                iter_next   = '0;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                if (sts.skip)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.mul_en = 1'b1;
                    iter_next  = iter_reg + 1'b1;
                    if (iter_reg == ITER_W'(MUL_STEPS - 1))
                    begin
                        state_next = S_DLOAD;
                    end
                end
            end
            S_DLOAD:
            begin
                cmd.dload_en = 1'b1;
                iter_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_en = 1'b1;
                iter_next  = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(DIV_STEPS - 1))
                begin
                    iter_next  = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_en = 1'b1;
                iter_next   = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(SQRT_STEPS - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // The result register is free once its previous transfer completes.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_ACC;
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACC;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/pca_dp.sv
// Datapath of the Pearson correlation accumulator core: running sums, shift-add
// multipliers, restoring divider, bitwise square root and result register. Uses pca_pkg.
`timescale 1ns / 1ps

module pca_dp
    import pca_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    input  logic [SAMPLE_BITS-1:0]   sample_x,
    input  logic [SAMPLE_BITS-1:0]   sample_y,
    output sts_t                     sts,
    output logic signed [CORR_W-1:0] corr_coeff,
    output logic [DET_W-1:0]         determination,
    output logic [REL_W-1:0]         relation,
    output logic [CNT_W-1:0]         pair_count
);

    localparam int PW    = 2 * SAMPLE_BITS;
    localparam int SH_W  = $clog2(ROOT_W);
    localparam int TSQ_W = 2 * ROOT_W;

    logic [CNT_W-1:0]  count_reg;
    logic [SUM_W-1:0]  sum_x_reg, sum_y_reg;
    logic [SQ_W-1:0]   sum_xx_reg, sum_yy_reg, sum_xy_reg;
    logic [CNT_W-1:0]  hold_cnt_reg;
    logic [PROD_W-1:0] mc_den_reg, mc_num_reg, acc_den_reg, acc_num_reg;
    logic [DIFF_W-1:0] mp_den_reg, mp_num_reg;
    logic              neg_reg, skip_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CORR_W-1:0] corr_reg;
    logic [DET_W-1:0]  det_reg;
    logic [REL_W-1:0]  rel_reg;

    logic [PW-1:0]     xx, yy, xy;
    logic [DIFF_W-1:0] nxy, sxsy, nxx, sxx, nyy, syy;
    logic [DIFF_W-1:0] num_abs, dx, dy;
    logic              num_pos, num_zero;
    logic [REM_W-1:0]  rem_sh, den_ext;
    logic [SH_W-1:0]   sh;
    logic [ROOT_W-1:0] trial;
    logic [TSQ_W-1:0]  trial_sq;
    logic [DET_W:0]    det_full;
    logic [ROOT_W-1:0] corr_pos;

    assign xx = PW'(sample_x) * PW'(sample_x);
    assign yy = PW'(sample_y) * PW'(sample_y);
    assign xy = PW'(sample_x) * PW'(sample_y);

    // Numerator and the two variance terms, all exact within DIFF_W bits.
    assign nxy  = DIFF_W'(count_reg) * DIFF_W'(sum_xy_reg);
    assign sxsy = DIFF_W'(sum_x_reg) * DIFF_W'(sum_y_reg);
    assign nxx  = DIFF_W'(count_reg) * DIFF_W'(sum_xx_reg);
    assign sxx  = DIFF_W'(sum_x_reg) * DIFF_W'(sum_x_reg);
    assign nyy  = DIFF_W'(count_reg) * DIFF_W'(sum_yy_reg);
    assign syy  = DIFF_W'(sum_y_reg) * DIFF_W'(sum_y_reg);

    assign num_pos  = (nxy >= sxsy);
    assign num_zero = (nxy == sxsy);
    assign num_abs  = num_pos ? (nxy - sxsy) : (sxsy - nxy);
    assign dx       = (nxx >= sxx) ? (nxx - sxx) : '0;
    assign dy       = (nyy >= syy) ? (nyy - syy) : '0;

    // The first division step uses the remainder unshifted (quotient weight 2^30).
    assign rem_sh  = (cmd.iter == '0) ? rem_reg : (rem_reg << 1);
    assign den_ext = REM_W'(acc_den_reg);

    assign sh       = SH_W'(ROOT_W - 1) - cmd.iter[SH_W-1:0];
    assign trial    = root_reg | (ROOT_W'(1) << sh);
    assign trial_sq = TSQ_W'(trial) * TSQ_W'(trial);

    assign det_full = quo_reg[QUO_W-1:DET_SHIFT];
    assign corr_pos = root_reg[ROOT_W-1] ? {1'b0, {(ROOT_W-1){1'b1}}} : root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xx_reg <= '0;
            sum_yy_reg <= '0;
            sum_xy_reg <= '0;
            skip_reg   <= 1'b0;
        end
        else if (cmd.prep_en)
        begin
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xx_reg <= '0;
            sum_yy_reg <= '0;
            sum_xy_reg <= '0;
            skip_reg   <= num_zero || (dx == '0) || (dy == '0);
        end
        else if (cmd.acc_en && (count_reg < CNT_W'(MAX_PAIRS)))
        begin
            count_reg  <= count_reg + 1'b1;
            sum_x_reg  <= sum_x_reg + SUM_W'(sample_x);
            sum_y_reg  <= sum_y_reg + SUM_W'(sample_y);
            sum_xx_reg <= sum_xx_reg + SQ_W'(xx);
            sum_yy_reg <= sum_yy_reg + SQ_W'(yy);
            sum_xy_reg <= sum_xy_reg + SQ_W'(xy);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep_en)
        begin
            hold_cnt_reg <= count_reg;
            neg_reg      <= !num_pos;
            mc_den_reg   <= PROD_W'(dx);
            mp_den_reg   <= dy;
            mc_num_reg   <= PROD_W'(num_abs);
            mp_num_reg   <= num_abs;
            acc_den_reg  <= '0;
            acc_num_reg  <= '0;
        end
        if (cmd.mul_en)
        begin
            acc_den_reg <= acc_den_reg + (mp_den_reg[0] ? mc_den_reg : '0);
            acc_num_reg <= acc_num_reg + (mp_num_reg[0] ? mc_num_reg : '0);
            mc_den_reg  <= mc_den_reg << 1;
            mc_num_reg  <= mc_num_reg << 1;
            mp_den_reg  <= mp_den_reg >> 1;
            mp_num_reg  <= mp_num_reg >> 1;
        end
        if (cmd.dload_en)
        begin
            rem_reg  <= REM_W'(acc_num_reg);
            quo_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.div_en)
        begin
            if (rem_sh >= den_ext)
            begin
                rem_reg <= rem_sh - den_ext;
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
        if (cmd.sqrt_en)
        begin
            if (trial_sq <= TSQ_W'(quo_reg))
            begin
                root_reg <= trial;
            end
        end
        if (cmd.out_load)
        begin
            if (skip_reg)
            begin
                corr_reg <= '0;
                det_reg  <= '0;
                rel_reg  <= REL_NONE;
            end
            else
            begin
                corr_reg <= neg_reg ? (CORR_W'(0) - root_reg) : corr_pos;
                det_reg  <= det_full[DET_W] ? {DET_W{1'b1}} : det_full[DET_W-1:0];
                rel_reg  <= neg_reg ? REL_NEG : REL_POS;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            pair_count <= hold_cnt_reg;
        end
    end

    assign sts.skip      = skip_reg;
    assign corr_coeff    = signed'(corr_reg);
    assign determination = det_reg;
    assign relation      = rel_reg;

endmodule

// File: rtl/pearson_correlation_accumulator_core.sv
// Pearson correlation accumulator core: input pairs arrive on in_valid/in_ready,
// one result per data set leaves on out_valid/out_ready. A pair that is not
// marked last is summed in the cycle it is taken, while fewer than MAX_PAIRS
// pairs are held (later pairs are taken but not summed), and the next pair can
// follow at once. A pair marked last is summed, then in_ready drops while the
// core works out the result: a set-up step, shift-add multiplication for the
// squared numerator and the denominator, a load step, restoring division and
// bitwise square root, then a load of the result register. A degenerate data
// set (zero numerator or denominator) skips the arithmetic. While the receiver
// stalls, the last result stays in its register and new pairs are still
// accepted; a following result waits until that transfer completes.
// Reset clears the sums, the pair count and all handshake state.
`timescale 1ns / 1ps
`include "pearson_correlation_accumulator_core_defines.svh"

module pearson_correlation_accumulator_core
    import pca_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [SAMPLE_BITS-1:0]   sample_x,
    input  logic [SAMPLE_BITS-1:0]   sample_y,
    input  logic                     last_pair,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [CORR_W-1:0] corr_coeff,
    output logic [DET_W-1:0]         determination,
    output logic [REL_W-1:0]         relation,
    output logic [CNT_W-1:0]         pair_count
);

    cmd_t cmd;
    sts_t sts;

    pca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_pair (last_pair),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pca_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sample_x      (sample_x),
        .sample_y      (sample_y),
        .sts           (sts),
        .corr_coeff    (corr_coeff),
        .determination (determination),
        .relation      (relation),
        .pair_count    (pair_count)
    );

    // A last-pair transfer closes the input until the result is built.
    `PCA_ASSERT_NEXT(a_last_closes_input, in_valid && in_ready && last_pair, !in_ready)
    // No relation means both result values are zero.
    `PCA_ASSERT_IMP(a_none_is_zero, out_valid && (relation == REL_NONE),
        (corr_coeff == '0) && (determination == '0))
    // A positive class never shows a negative coefficient.
    `PCA_ASSERT_IMP(a_pos_sign, out_valid && (relation == REL_POS), !corr_coeff[CORR_W-1])
    // The reported count never passes capacity.
    `PCA_ASSERT_IMP(a_count_cap, out_valid, pair_count <= CNT_W'(MAX_PAIRS))

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for pearson_correlation_accumulator_core.
// Depends on pca_pkg for widths and relation codes; drives pairs with random gaps and
// checks each result against typed-in values or an exact predictor of r, r^2, class.
`timescale 1ns / 1ps

module tb_top;
    import pca_pkg::*;

    localparam int  DIR_N       = 17;
    localparam int  RAND_ITEMS  = 1100;
    localparam int  CYCLE_LIMIT = 600000;
    localparam int  DRAIN_WAIT  = 150;

    typedef struct packed {
        logic signed [CORR_W-1:0] corr;
        logic [DET_W-1:0]         det;
        logic [REL_W-1:0]         rel;
        logic [CNT_W-1:0]         cnt;
    } corr_result_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] x;
        logic [SAMPLE_BITS-1:0] y;
        logic                   last;
        logic                   has_exp;
        corr_result_t           exp_res;
    } pair_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [SAMPLE_BITS-1:0]   sample_x = '0;
    logic [SAMPLE_BITS-1:0]   sample_y = '0;
    logic                     last_pair = 1'b0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [CORR_W-1:0] corr_coeff;
    logic [DET_W-1:0]         determination;
    logic [REL_W-1:0]         relation;
    logic [CNT_W-1:0]         pair_count;

    // Typed-in expectation travelling with the pair currently on the bus.
    logic                     cur_has_exp = 1'b0;
    corr_result_t             cur_exp = '0;

    pair_row_t    dir_rows [DIR_N];
    corr_result_t result_queue [$];
    int           error_count = 0;
    int           cycle_count = 0;

    // Predictor copy of the accumulator state.
    logic [CNT_W-1:0] acc_n = '0;
    logic [255:0]     acc_sx = '0, acc_sy = '0, acc_sxx = '0, acc_syy = '0, acc_sxy = '0;

    pearson_correlation_accumulator_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_x      (sample_x),
        .sample_y      (sample_y),
        .last_pair     (last_pair),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .corr_coeff    (corr_coeff),
        .determination (determination),
        .relation      (relation),
        .pair_count    (pair_count)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Accumulates one pair; on a last pair returns the correlation result and clears.
    task automatic correlate_pair(input logic [15:0] x, input logic [15:0] y,
                                  input logic last, output logic fire,
                                  output corr_result_t res);
        logic [255:0] n, p, q, num, dx, dy, den, num2, tgt, lo, hi, mid;
        logic         neg;
        fire = 1'b0;
        res = '0;
        if (acc_n < MAX_PAIRS)
        begin
            acc_n   = acc_n + 1'b1;
            acc_sx  = acc_sx + 256'(x);
            acc_sy  = acc_sy + 256'(y);
            acc_sxx = acc_sxx + 256'(x) * 256'(x);
            acc_syy = acc_syy + 256'(y) * 256'(y);
            acc_sxy = acc_sxy + 256'(x) * 256'(y);
        end
        if (last)
        begin
            fire = 1'b1;
            n = 256'(acc_n);
            p = n * acc_sxy;
            q = acc_sx * acc_sy;
            neg = (p < q);
            num = neg ? q - p : p - q;
            p = n * acc_sxx;
            q = acc_sx * acc_sx;
            dx = (p > q) ? p - q : '0;
            p = n * acc_syy;
            q = acc_sy * acc_sy;
            dy = (p > q) ? p - q : '0;
            den = dx * dy;
            res.rel = REL_NONE;
            if (den != 0 && num != 0)
            begin
                num2 = num * num;
                tgt = num2 << 30;
                lo = '0;
                hi = 256'(32768);
                while (lo < hi)
                begin
                    mid = lo + (hi - lo + 1) / 2;
                    if (mid * mid * den <= tgt)
                        lo = mid;
                    else
                        hi = mid - 1;
                end
                if (!neg)
                begin
                    res.corr = (lo > 32767) ? 16'sd32767 : lo[15:0];
                    res.rel = REL_POS;
                end
                else
                begin
                    res.corr = 16'(17'h10000 - lo[16:0]);
                    res.rel = REL_NEG;
                end
                tgt = (num2 << 16) / den;
                res.det = (tgt > 65535) ? 16'hFFFF : tgt[15:0];
            end
            res.cnt = acc_n;
            acc_n = '0;
            acc_sx = '0;
            acc_sy = '0;
            acc_sxx = '0;
            acc_syy = '0;
            acc_sxy = '0;
        end
    endtask

    always @(posedge clk)
    begin : accept_monitor
        logic         fire;
        corr_result_t res;
        if (rst_n && in_valid && in_ready)
        begin
            correlate_pair(sample_x, sample_y, last_pair, fire, res);
            if (fire)
                result_queue.push_back(cur_has_exp ? cur_exp : res);
        end
    end

    always @(posedge clk)
    begin : result_monitor
        corr_result_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (result_queue.size() == 0)
            begin
                $error("result transfer with no expected result pending");
                error_count++;
            end
            else
            begin
                exp_res = result_queue.pop_front();
                if (corr_coeff !== exp_res.corr)
                begin
                    $error("corr_coeff expected %0d actual %0d", exp_res.corr, corr_coeff);
                    error_count++;
                end
                if (determination !== exp_res.det)
                begin
                    $error("determination expected %0d actual %0d", exp_res.det,
                           determination);
                    error_count++;
                end
                if (relation !== exp_res.rel)
                begin
                    $error("relation expected %0d actual %0d", exp_res.rel, relation);
                    error_count++;
                end
                if (pair_count !== exp_res.cnt)
                begin
                    $error("pair_count expected %0d actual %0d", exp_res.cnt, pair_count);
                    error_count++;
                end
            end
        end
    end

    // Receiver: random stall before each result transfer.
    initial
    begin : receiver
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 12);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_pair(input logic [15:0] x, input logic [15:0] y, input logic last,
                             input logic has_exp, input corr_result_t exp_res,
                             input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        sample_x    <= x;
        sample_y    <= y;
        last_pair   <= last;
        cur_has_exp <= has_exp;
        cur_exp     <= exp_res;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic pair_row_t mk_row(int x, int y, bit last, bit has_exp = 0,
                                         int corr = 0, int det = 0,
                                         rel_t rel = REL_NONE, int cnt = 0);
        pair_row_t r;
        r.x = x[15:0];
        r.y = y[15:0];
        r.last = last;
        r.has_exp = has_exp;
        r.exp_res.corr = corr[15:0];
        r.exp_res.det = det[15:0];
        r.exp_res.rel = rel;
        r.exp_res.cnt = cnt[6:0];
        return r;
    endfunction

    initial
    begin : stimulus
        int           len, mode, base, gap, sent;
        bit           busy;
        logic [15:0]  x, y;

        // Single pair, full-scale positive and negative, constant x, constant y,
        // perfect line, zero numerator, then arbitrary values left to the predictor.
        dir_rows[0]  = mk_row(1234, 4321, 1, 1, 0, 0, REL_NONE, 1);
        dir_rows[1]  = mk_row(0, 0, 0);
        dir_rows[2]  = mk_row(65535, 65535, 1, 1, 32767, 65535, REL_POS, 2);
        dir_rows[3]  = mk_row(0, 65535, 0);
        dir_rows[4]  = mk_row(65535, 0, 1, 1, -32768, 65535, REL_NEG, 2);
        dir_rows[5]  = mk_row(7, 100, 0);
        dir_rows[6]  = mk_row(7, 200, 1, 1, 0, 0, REL_NONE, 2);
        dir_rows[7]  = mk_row(10, 3, 0);
        dir_rows[8]  = mk_row(20, 3, 1, 1, 0, 0, REL_NONE, 2);
        dir_rows[9]  = mk_row(1, 1, 0);
        dir_rows[10] = mk_row(2, 2, 0);
        dir_rows[11] = mk_row(3, 3, 1, 1, 32767, 65535, REL_POS, 3);
        dir_rows[12] = mk_row(1, 2, 0);
        dir_rows[13] = mk_row(2, 1, 0);
        dir_rows[14] = mk_row(3, 2, 1, 1, 0, 0, REL_NONE, 3);
        dir_rows[15] = mk_row(100, 5000, 0);
        dir_rows[16] = mk_row(40000, 300, 1);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
            send_pair(dir_rows[i].x, dir_rows[i].y, dir_rows[i].last, dir_rows[i].has_exp,
                      dir_rows[i].exp_res, $urandom_range(0, 12));

        // Hold off until the core has drained every directed result.
        in_valid <= 1'b0;
        while (result_queue.size() != 0) @(posedge clk);

        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            len  = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 80)
                                                 : $urandom_range(1, 10);
            mode = $urandom_range(0, 4);
            base = $urandom_range(0, 65535);
            busy = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++)
            begin
                x = 16'($urandom_range(0, 65535));
                case (mode)
                    0: y = 16'($urandom_range(0, 65535));
                    1: y = x + 16'($urandom_range(0, 2000));
                    2: y = ~x ^ 16'($urandom_range(0, 255));
                    3:
                    begin
                        x = base[15:0];
                        y = 16'($urandom_range(0, 65535));
                    end
                    default:
                    begin
                        x = 16'($urandom_range(0, 3));
                        y = 16'($urandom_range(0, 3));
                    end
                endcase
                gap = busy ? 0 : $urandom_range(0, 12);
                send_pair(x, y, i == len - 1, 1'b0, '0, gap);
                sent++;
            end
        end
        in_valid <= 1'b0;

        while (result_queue.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0 && result_queue.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
